@@ hdl/hdlc_nrzi_frame_bit_encoder_assert.svh @@
// Assertion macros for the frame bit encoder checker.
`ifndef HDLC_NRZI_FRAME_BIT_ENCODER_ASSERT_SVH
`define HDLC_NRZI_FRAME_BIT_ENCODER_ASSERT_SVH

// Same-cycle implication, masked while reset is low.
`define HNE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hne assertion failed");

// Next-cycle implication, masked while reset is low.
`define HNE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hne assertion failed");

// Next-cycle implication that also holds across reset.
`define HNE_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("hne assertion failed");

`endif

@@ hdl/hne_pkg.sv @@
package hne_pkg;

    localparam logic [1:0] CMD_DATA = 2'd0;
    localparam logic [1:0] CMD_FLAG = 2'd1;
    localparam logic [1:0] CMD_FCS  = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h8408;  // x^16+x^12+x^5+1, reflected
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [2:0]  STUFF_AT  = 3'd4;      // ones seen before the fifth

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic line_bit;
        logic stuffed;
        logic last;
    } t_out;

    typedef struct packed {
        logic init;
        logic step;
        logic bit_in;
    } t_crc_req;

    typedef struct packed {
        logic step;
        logic bit_in;
        logic stuff_en;
        logic stuff_bit;
        logic clr_ones;
    } t_line_req;

    typedef struct packed {
        logic tone_next;
        logic need_stuff;
    } t_line_rsp;

endpackage

@@ hdl/hne_crc.sv @@
// Bit-serial CRC-16/X.25, reflected, one bit per step.
module hne_crc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hne_pkg::t_crc_req i_req,
    output logic [15:0]       o_crc
);

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic        w_fb;

    assign w_fb = r_crc[0] ^ i_req.bit_in;

    always_comb begin
        n_crc = r_crc;
        if (i_req.init) begin
            n_crc = hne_pkg::CRC_INIT;
        end else if (i_req.step) begin
            n_crc = (r_crc >> 1) ^ (w_fb ? hne_pkg::CRC_POLY : 16'h0000);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= hne_pkg::CRC_INIT;
        end else begin
            r_crc <= n_crc;
        end
    end

    assign o_crc = r_crc;

endmodule

@@ hdl/hne_line.sv @@
// NRZI tone state and ones-run counter for bit stuffing.
module hne_line (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hne_pkg::t_line_req i_req,
    output hne_pkg::t_line_rsp o_rsp
);

    logic       r_tone;
    logic [2:0] r_ones;
    logic       n_tone;
    logic [2:0] n_ones;

    // zero (data or stuffed) toggles the tone, one keeps it
    assign o_rsp.tone_next  = r_tone ^ (i_req.stuff_bit | ~i_req.bit_in);
    assign o_rsp.need_stuff = i_req.stuff_en & i_req.bit_in & ~i_req.stuff_bit
                              & (r_ones == hne_pkg::STUFF_AT);

    always_comb begin
        n_tone = r_tone;
        n_ones = r_ones;
        if (i_req.clr_ones) begin
            n_ones = 3'd0;
        end
        if (i_req.step) begin
            n_tone = o_rsp.tone_next;
            if (i_req.stuff_bit) begin
                n_ones = 3'd0;
            end else if (i_req.stuff_en) begin
                n_ones = i_req.bit_in ? r_ones + 3'd1 : 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone <= 1'b0;
            r_ones <= 3'd0;
        end else begin
            r_tone <= n_tone;
            r_ones <= n_ones;
        end
    end

endmodule

@@ hdl/hdlc_nrzi_frame_bit_encoder.sv @@
// HDLC / AX.25 frame bit encoder with NRZI line coding.
// Input channel (i_in_*): one transfer per byte command. cmd selects a data
// byte (bit-stuffed, fed to the CRC), a flag byte 0x7E (unstuffed, restarts
// CRC and ones count) or end of frame (sends the complemented CRC-16/X.25,
// low bit first, stuffed). The reserved command is taken and dropped.
// Output channel (o_out_*): one transfer per line bit, with the tone after
// the bit, a stuffed-bit marker and a last marker on the item's final bit.
// An accepted item is loaded into the sequencer state first; its line bits
// are then registered one by one in the output register.
// Throughput: one line bit per cycle from a single serializer while the
// output register is free or being taken. o_in_ready is low while a burst
// is in flight: a new item is taken only after the last bit of the one before.
// Receiver stall: a single output register holds the pending bit; the
// serializer simply pauses until it is taken, nothing is dropped.
// Reset (synchronous, active low): output empty, tone at mark, ones count
// zero, CRC at all ones, block ready.
module hdlc_nrzi_frame_bit_encoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hne_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hne_pkg::t_out o_out_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SEND = 1'b1;

    // sequencer state
    logic          r_state,     n_state;
    logic [15:0]   r_shift,     n_shift;      // bits still to send, LSB next
    logic [4:0]    r_cnt,       n_cnt;        // source bits left, up to 16
    logic          r_stuff_en,  n_stuff_en;
    logic          r_is_data,   n_is_data;    // bits feed the CRC
    logic          r_stuff_pend, n_stuff_pend; // stuffed zero owed next
    // output register
    logic          r_out_valid, n_out_valid;
    hne_pkg::t_out r_out_data,  n_out_data;

    logic               w_in_xfer;
    logic               w_adv;
    logic               w_last;
    logic [15:0]        w_crc;
    hne_pkg::t_crc_req  w_crc_req;
    hne_pkg::t_line_req w_line_req;
    hne_pkg::t_line_rsp w_line_rsp;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_in_xfer  = i_in_valid & o_in_ready;
    // one line bit per cycle in SEND, whenever the output slot is free or draining
    assign w_adv      = (r_state == ST_SEND) & (~r_out_valid | i_out_ready);

    hne_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_crc_req),
        .o_crc   (w_crc)
    );

    hne_line u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_line_req),
        .o_rsp   (w_line_rsp)
    );

    always_comb begin
        n_state      = r_state;
        n_shift      = r_shift;
        n_cnt        = r_cnt;
        n_stuff_en   = r_stuff_en;
        n_is_data    = r_is_data;
        n_stuff_pend = r_stuff_pend;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_out_data   = r_out_data;
        w_crc_req    = '0;
        w_line_req   = '0;
        w_last       = 1'b0;

        // load a new burst
        if (w_in_xfer) begin
            unique case (i_in_data.cmd)
                hne_pkg::CMD_DATA: begin
                    n_shift    = {8'h00, i_in_data.data_byte};
                    n_cnt      = 5'd8;
                    n_stuff_en = 1'b1;
                    n_is_data  = 1'b1;
                    n_state    = ST_SEND;
                end
                hne_pkg::CMD_FLAG: begin
                    // flag bits bypass CRC and stuffing, so both restart now
                    n_shift            = {8'h00, hne_pkg::FLAG_BYTE};
                    n_cnt              = 5'd8;
                    n_stuff_en         = 1'b0;
                    n_is_data          = 1'b0;
                    w_crc_req.init     = 1'b1;
                    w_line_req.clr_ones = 1'b1;
                    n_state            = ST_SEND;
                end
                hne_pkg::CMD_FCS: begin
                    // snapshot the complemented CRC, then restart it
                    n_shift        = ~w_crc;
                    n_cnt          = 5'd16;
                    n_stuff_en     = 1'b1;
                    n_is_data      = 1'b0;
                    w_crc_req.init = 1'b1;
                    n_state        = ST_SEND;
                end
                default: begin
                    // reserved command: dropped
                end
            endcase
        end

        // emit one line bit
        if (w_adv) begin
            n_out_valid     = 1'b1;
            w_line_req.step = 1'b1;
            if (r_stuff_pend) begin
                w_line_req.stuff_bit = 1'b1;
                w_last               = (r_cnt == 5'd0);
                n_stuff_pend         = 1'b0;
                n_out_data.line_bit  = w_line_rsp.tone_next;
                n_out_data.stuffed   = 1'b1;
                n_out_data.last      = w_last;
            end else begin
                w_line_req.bit_in   = r_shift[0];
                w_line_req.stuff_en = r_stuff_en;
                w_crc_req.step      = r_is_data;
                w_crc_req.bit_in    = r_shift[0];
                n_shift             = r_shift >> 1;
                n_cnt               = r_cnt - 5'd1;
                n_stuff_pend        = w_line_rsp.need_stuff;
                w_last              = (r_cnt == 5'd1) & ~w_line_rsp.need_stuff;
                n_out_data.line_bit = w_line_rsp.tone_next;
                n_out_data.stuffed  = 1'b0;
                n_out_data.last     = w_last;
            end
            if (w_last) begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_stuff_pend <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cnt        <= 5'd0;
        end else begin
            r_state      <= n_state;
            r_stuff_pend <= n_stuff_pend;
            r_out_valid  <= n_out_valid;
            r_cnt        <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_stuff_en <= n_stuff_en;
        r_is_data  <= n_is_data;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ hdl/hne_checker.sv @@
`include "hdlc_nrzi_frame_bit_encoder_assert.svh"

module hne_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          o_in_ready,
    input  hne_pkg::t_in  i_in_data,
    input  logic          o_out_valid,
    input  logic          i_out_ready,
    input  hne_pkg::t_out o_out_data
);

    // a stalled line bit stays offered
    `HNE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // a real command closes the input until its burst is done
    `HNE_ASSERT_NEXT(a_busy_after_cmd, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_data.cmd != hne_pkg::CMD_RSVD, !o_in_ready)

    // mid-burst bits never coexist with an open input
    `HNE_ASSERT_SAME(a_ready_only_at_end, i_clk, i_rst_n, o_out_valid && !o_out_data.last, !o_in_ready)

    // reset empties the output register
    `HNE_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind hdlc_nrzi_frame_bit_encoder hne_checker u_hne_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    // Expected line bits are built from a private copy of the encoder state:
    // NRZI tone, stuffing run length and the CRC-16/X.25 register.
    class nrzi_scoreboard;
        hne_pkg::t_out pending_bits[$];
        logic          tone;
        int            ones_run;
        logic [15:0]   fcs_crc;
        int            mismatches;
        int            bits_checked;
        int            stuffed_seen;

        function new();
            tone         = 1'b0;
            ones_run     = 0;
            fcs_crc      = hne_pkg::CRC_INIT;
            mismatches   = 0;
            bits_checked = 0;
            stuffed_seen = 0;
        endfunction

        function int outstanding();
            return pending_bits.size();
        endfunction

        function void push_bit(logic is_stuffed);
            hne_pkg::t_out b;
            b.line_bit = tone;
            b.stuffed  = is_stuffed;
            b.last     = 1'b0;
            pending_bits.push_back(b);
        endfunction

        // Zero toggles the tone, one keeps it; after the fifth one in the
        // stuffed domain an extra zero goes out.
        function void send_line_bit(logic b, logic stuff_en);
            if (b) begin
                push_bit(1'b0);
                if (stuff_en) begin
                    ones_run++;
                    if (ones_run == 5) begin
                        tone = ~tone;
                        push_bit(1'b1);
                        ones_run = 0;
                    end
                end
            end else begin
                tone = ~tone;
                push_bit(1'b0);
                if (stuff_en) ones_run = 0;
            end
        endfunction

        function void crc_shift(logic b);
            logic fb;
            fb      = fcs_crc[0] ^ b;
            fcs_crc = fcs_crc >> 1;
            if (fb) fcs_crc = fcs_crc ^ hne_pkg::CRC_POLY;
        endfunction

        // Called for every accepted input transfer.
        function void predict_bits(hne_pkg::t_in it);
            int            n0;
            logic [15:0]   fcs;
            hne_pkg::t_out tail;
            n0 = pending_bits.size();
            case (it.cmd)
                hne_pkg::CMD_DATA: begin
                    for (int i = 0; i < 8; i++) begin
                        crc_shift(it.data_byte[i]);
                        send_line_bit(it.data_byte[i], 1'b1);
                    end
                end
                hne_pkg::CMD_FLAG: begin
                    for (int i = 0; i < 8; i++)
                        send_line_bit(hne_pkg::FLAG_BYTE[i], 1'b0);
                    fcs_crc  = hne_pkg::CRC_INIT;
                    ones_run = 0;
                end
                hne_pkg::CMD_FCS: begin
                    fcs = ~fcs_crc;
                    for (int i = 0; i < 16; i++) send_line_bit(fcs[i], 1'b1);
                    fcs_crc = hne_pkg::CRC_INIT;
                end
                default: return;
            endcase
            if (pending_bits.size() > n0) begin
                tail = pending_bits.pop_back();
                tail.last = 1'b1;
                pending_bits.push_back(tail);
            end
        endfunction

        // Called for every accepted output transfer.
        function void check_bit(hne_pkg::t_out got);
            hne_pkg::t_out want;
            bits_checked++;
            if (got.stuffed === 1'b1) stuffed_seen++;
            if (pending_bits.size() == 0) begin
                $display("%0t: unexpected line bit, expected none, actual %b", $time, got);
                mismatches++;
                return;
            end
            want = pending_bits.pop_front();
            if (got.line_bit !== want.line_bit) begin
                $display("%0t: line_bit mismatch, expected %b, actual %b",
                         $time, want.line_bit, got.line_bit);
                mismatches++;
            end
            if (got.stuffed !== want.stuffed) begin
                $display("%0t: stuffed mismatch, expected %b, actual %b",
                         $time, want.stuffed, got.stuffed);
                mismatches++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last mismatch, expected %b, actual %b",
                         $time, want.last, got.last);
                mismatches++;
            end
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 100;
    localparam int HOLD_CYCLES  = 100;  // long receiver stall, fills the block
    localparam int SETTLE       = 40;   // quiet cycles after the last bit

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    hne_pkg::t_in  i_in_data   = '0;
    logic          i_out_ready = 1'b0;
    logic          o_in_ready;
    logic          o_out_valid;
    hne_pkg::t_out o_out_data;

    nrzi_scoreboard sb;

    // hold_off_req is shared between sender and receiver; no_gaps only steers the sender.
    logic hold_off_req = 1'b0;
    logic no_gaps      = 1'b0;

    int items_sent;  // reserved commands not counted
    int n_data, n_flag, n_fcs, n_rsvd;

    hdlc_nrzi_frame_bit_encoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Transfer monitor: everything is sampled at the rising edge, while the
    // stimulus only moves on falling edges, so there is no race here.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.predict_bits(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_bit(o_out_data);
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Bias data toward runs of ones so stuffing shows up often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'hFF;
            1: return 8'h1F << $urandom_range(0, 3);
            2: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one item and hold it until the block takes it, then an
    // optional idle gap with junk on the bus.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] byte_val);
        hne_pkg::t_in it;
        int           gap;
        it.cmd       = cmd;
        it.data_byte = byte_val;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        case (cmd)
            hne_pkg::CMD_DATA: n_data++;
            hne_pkg::CMD_FLAG: n_flag++;
            hne_pkg::CMD_FCS:  n_fcs++;
            default:           n_rsvd++;
        endcase
        if (cmd != hne_pkg::CMD_RSVD) items_sent++;
        gap = no_gaps ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_in_data  <= hne_pkg::t_in'(10'($urandom));
        end
    endtask

    // Stop offering and wait for every predicted bit to come out.
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Receiver: random stalls, streaks of steady ready, and one long
    // hold-off on request from the sender.
    initial begin
        int stall;
        int streak;
        int r;
        stall  = 0;
        streak = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (streak > 0) begin
                    streak--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 10)      streak = $urandom_range(20, 60);
                    else if (r < 40) stall  = $urandom_range(1, 3);
                    else if (r < 45) stall  = $urandom_range(10, 30);
                end
            end
        end
    end

    // Run limit: far beyond the slowest legal run of this stimulus.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int   base;
        int   nd;
        logic hold_done;
        logic pause_done;
        sb         = new();
        items_sent = 0;
        n_data     = 0;
        n_flag     = 0;
        n_fcs      = 0;
        n_rsvd     = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, stuffing inside and across bytes, all
        // commands, empty frame, flag clearing a pending ones run.
        send_item(hne_pkg::CMD_FLAG, 8'h00);
        send_item(hne_pkg::CMD_DATA, 8'h00);
        send_item(hne_pkg::CMD_DATA, 8'hFF);
        send_item(hne_pkg::CMD_DATA, 8'hFF);
        send_item(hne_pkg::CMD_DATA, 8'h1F);
        send_item(hne_pkg::CMD_DATA, 8'hF8);
        send_item(hne_pkg::CMD_DATA, 8'h80);
        send_item(hne_pkg::CMD_DATA, 8'h01);
        send_item(hne_pkg::CMD_DATA, 8'hAA);
        send_item(hne_pkg::CMD_DATA, 8'h55);
        send_item(hne_pkg::CMD_DATA, 8'h7E);
        send_item(hne_pkg::CMD_FCS,  8'hFF);
        send_item(hne_pkg::CMD_FLAG, 8'hFF);
        send_item(hne_pkg::CMD_FCS,  8'h00);   // empty frame
        send_item(hne_pkg::CMD_RSVD, 8'hFF);   // dropped by the block
        send_item(hne_pkg::CMD_RSVD, 8'h00);
        send_item(hne_pkg::CMD_FLAG, 8'hA5);
        send_item(hne_pkg::CMD_DATA, 8'hFF);   // leaves a run of three ones
        send_item(hne_pkg::CMD_FLAG, 8'h5A);   // ...which the flag clears
        send_item(hne_pkg::CMD_DATA, 8'h0F);
        send_item(hne_pkg::CMD_DATA, 8'hF0);
        send_item(hne_pkg::CMD_FCS,  8'hAB);
        send_item(hne_pkg::CMD_FLAG, 8'h3C);
        wait_drained();

        // Random: mostly well-formed frames with random content, plus
        // noise and frames cut short before their check sequence.
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (!hold_done && items_sent - base >= 40) begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && items_sent - base >= 80) begin
                wait_drained();
                pause_done = 1'b1;
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8) begin
                repeat ($urandom_range(1, 2)) send_item(hne_pkg::CMD_FLAG, 8'($urandom));
                nd = $urandom_range(0, 6);
                repeat (nd) send_item(hne_pkg::CMD_DATA, pick_byte());
                if ($urandom_range(0, 9) != 0) send_item(hne_pkg::CMD_FCS, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(2'($urandom_range(0, 3)), 8'($urandom));
            end
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);

        $display("covered %0d data, %0d flag, %0d end-of-frame and %0d reserved commands",
                 n_data, n_flag, n_fcs, n_rsvd);
        $display("checked %0d line bits, %0d of them stuffing zeros, %0d errors",
                 sb.bits_checked, sb.stuffed_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/hne_pkg.sv
hdl/hne_crc.sv
hdl/hne_line.sv
hdl/hdlc_nrzi_frame_bit_encoder.sv
hdl/hne_checker.sv
dv/testbench.sv
